// ----- rtl/drpl_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpl_pkg
// Types, widths, codes and small helper functions of the ROI point locator.
// ----------------------------------------------------------------------------
package drpl_pkg;

    localparam int COORD_BITS = 11;
    localparam int DEPTH_BITS = 16;
    localparam int SUM_BITS   = 36;
    localparam int COUNT_BITS = 18;
    localparam int CONF_BITS  = 16;
    localparam int TAG_BITS   = 16;
    localparam int FOCAL_BITS = 20;
    localparam int PRIN_BITS  = 19;
    localparam int HALF_BITS  = 8;
    localparam int OFF_BITS   = 18;
    localparam int RANGE_BITS = 16;

    // shared divider: numerator covers both the depth sum and the projection product
    localparam int DIV_NUM_BITS = 40;
    localparam int DIV_DEN_BITS = 20;

    // configuration register indexes
    localparam logic [2:0] CFG_FOCAL   = 3'd0;
    localparam logic [2:0] CFG_PRIN_X  = 3'd1;
    localparam logic [2:0] CFG_PRIN_Y  = 3'd2;
    localparam logic [2:0] CFG_HALF_C  = 3'd3;
    localparam logic [2:0] CFG_HALF_R  = 3'd4;
    localparam logic [2:0] CFG_LAST_C  = 3'd5;
    localparam logic [2:0] CFG_LAST_R  = 3'd6;

    // item kinds
    localparam logic [1:0] FUNC_BOX   = 2'd0;
    localparam logic [1:0] FUNC_PIXEL = 2'd1;
    localparam logic [1:0] FUNC_START = 2'd2;

    // result status codes
    localparam logic [1:0] ST_LOCATED = 2'd0;
    localparam logic [1:0] ST_NO_OBJ  = 2'd1;
    localparam logic [1:0] ST_NO_DEPTH = 2'd2;

    // input tdata layout
    localparam int IN_CONF_LO   = 0;
    localparam int IN_LEFT_LO   = IN_CONF_LO + CONF_BITS;
    localparam int IN_TOP_LO    = IN_LEFT_LO + COORD_BITS;
    localparam int IN_RIGHT_LO  = IN_TOP_LO + COORD_BITS;
    localparam int IN_BOTTOM_LO = IN_RIGHT_LO + COORD_BITS;
    localparam int IN_ROW_LO    = IN_BOTTOM_LO + COORD_BITS;
    localparam int IN_COL_LO    = IN_ROW_LO + COORD_BITS;
    localparam int IN_DEPTH_LO  = IN_COL_LO + COORD_BITS;
    localparam int IN_TAG_LO    = IN_DEPTH_LO + DEPTH_BITS;
    localparam int IN_USED      = IN_TAG_LO + TAG_BITS;
    localparam int IN_DATA_BITS = ((IN_USED + 7) / 8) * 8;

    // output tdata layout
    localparam int OUT_TAG_LO   = 0;
    localparam int OUT_CCOL_LO  = OUT_TAG_LO + TAG_BITS;
    localparam int OUT_CROW_LO  = OUT_CCOL_LO + COORD_BITS;
    localparam int OUT_LAT_LO   = OUT_CROW_LO + COORD_BITS;
    localparam int OUT_VERT_LO  = OUT_LAT_LO + OFF_BITS;
    localparam int OUT_RANGE_LO = OUT_VERT_LO + OFF_BITS;
    localparam int OUT_USED     = OUT_RANGE_LO + RANGE_BITS;
    localparam int OUT_DATA_BITS = ((OUT_USED + 7) / 8) * 8;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef struct packed {
        t_coord left;
        t_coord top;
        t_coord right;
        t_coord bottom;
    } t_box;

    // one frame-end job handed from the front to the back
    typedef struct packed {
        logic [TAG_BITS-1:0]   tag;
        logic                  found;
        t_coord                ccol;
        t_coord                crow;
        logic [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0] count;
    } t_job;

    typedef struct packed {
        logic [1:0]            status;
        logic [TAG_BITS-1:0]   tag;
        t_coord                ccol;
        t_coord                crow;
        logic [OFF_BITS-1:0]   lateral;
        logic [OFF_BITS-1:0]   vertical;
        logic [RANGE_BITS-1:0] range_mm;
    } t_result;

    // lo + (hi - lo) / 2 with the halving truncated toward zero
    function automatic t_coord centre_of(input t_coord lo, input t_coord hi);
        logic signed [COORD_BITS+1:0] d;
        logic signed [COORD_BITS+1:0] h;
        logic [COORD_BITS+1:0]        s;
        d = $signed({2'b00, hi}) - $signed({2'b00, lo});
        h = (d + $signed({{(COORD_BITS+1){1'b0}}, d[COORD_BITS+1]})) >>> 1;
        s = {2'b00, lo} + h;
        return s[COORD_BITS-1:0];
    endfunction

    // c - half, held at zero and at the box edge
    function automatic t_coord lo_clip(input t_coord c, input logic [HALF_BITS-1:0] half,
                                       input t_coord box_lo);
        logic signed [COORD_BITS+1:0] v;
        t_coord                       r;
        v = $signed({2'b00, c}) - $signed({{(COORD_BITS+2-HALF_BITS){1'b0}}, half});
        r = v[COORD_BITS+1] ? '0 : v[COORD_BITS-1:0];
        return (r < box_lo) ? box_lo : r;
    endfunction

    // c + half, held at the image limit and at the box edge
    function automatic t_coord hi_clip(input t_coord c, input logic [HALF_BITS-1:0] half,
                                       input t_coord limit, input t_coord box_hi);
        logic [COORD_BITS:0] v;
        t_coord              r;
        v = {1'b0, c} + {{(COORD_BITS+1-HALF_BITS){1'b0}}, half};
        r = (v > {1'b0, limit}) ? limit : v[COORD_BITS-1:0];
        return (r > box_hi) ? box_hi : r;
    endfunction

endpackage

// ----- rtl/drpl_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpl_front
// Takes every item: box reduction, window latching, depth accumulation and
// frame-end job hand-off to the queue.
// ----------------------------------------------------------------------------
module drpl_front
    import drpl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_take,
    input  logic [1:0]            i_func,
    input  logic                  i_last,
    input  logic                  i_present,
    input  logic [CONF_BITS-1:0]  i_conf,
    input  t_box                  i_box,
    input  t_coord                i_row,
    input  t_coord                i_col,
    input  logic [DEPTH_BITS-1:0] i_depth,
    input  logic [TAG_BITS-1:0]   i_tag,
    input  logic [HALF_BITS-1:0]  i_half_cols,
    input  logic [HALF_BITS-1:0]  i_half_rows,
    input  t_coord                i_last_col,
    input  t_coord                i_last_row,
    output logic                  o_push,
    output t_job                  o_job
);

    localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    logic                  r_armed, r_found, r_in_frame;
    logic [TAG_BITS-1:0]   r_tag;
    logic [CONF_BITS-1:0]  r_best_conf;
    t_box                  r_best_box, r_box;
    t_coord                r_ccol, r_crow;
    t_box                  r_win;   // left=x1 top=x2 right=y1 bottom=y2
    logic [SUM_BITS-1:0]   r_sum;
    logic [COUNT_BITS-1:0] r_count;

    logic                  is_box, is_pix, is_start, better;
    logic [CONF_BITS-1:0]  eff_conf;
    t_box                  eff_box, new_win, win;
    logic [SUM_BITS-1:0]   base_sum, n_sum;
    logic [SUM_BITS:0]     sum_ext;
    logic [COUNT_BITS-1:0] base_count, n_count;
    logic                  hit;

    assign is_box   = i_take && (i_func == FUNC_BOX);
    assign is_pix   = i_take && (i_func == FUNC_PIXEL);
    assign is_start = i_take && (i_func == FUNC_START);

    // running best box including the current one
    assign better   = i_present && (i_conf > r_best_conf);
    assign eff_conf = better ? i_conf : r_best_conf;
    assign eff_box  = better ? i_box : r_best_box;

    // window from the committed box, used at the first pixel of a frame
    always_comb begin
        new_win.left   = lo_clip(r_ccol, i_half_cols, r_box.left);
        new_win.top    = hi_clip(r_ccol, i_half_cols, i_last_col, r_box.right);
        new_win.right  = lo_clip(r_crow, i_half_rows, r_box.top);
        new_win.bottom = hi_clip(r_crow, i_half_rows, i_last_row, r_box.bottom);
    end
    assign win = r_in_frame ? r_win : new_win;

    // saturating accumulation of valid depths strictly inside the window
    always_comb begin
        base_sum   = r_in_frame ? r_sum : '0;
        base_count = r_in_frame ? r_count : '0;
        hit = (i_depth != '0) && (i_col > win.left) && (i_col < win.top) &&
              (i_row > win.right) && (i_row < win.bottom);
        sum_ext = {1'b0, base_sum} + {{(SUM_BITS+1-DEPTH_BITS){1'b0}}, i_depth};
        n_sum   = base_sum;
        n_count = base_count;
        if (hit) begin
            n_sum = sum_ext[SUM_BITS] ? SUM_MAX : sum_ext[SUM_BITS-1:0];
            if (base_count != COUNT_MAX) begin
                n_count = base_count + 1'b1;
            end
        end
    end

    // job for the back at an armed frame end
    assign o_push = is_pix && i_last && r_armed;
    always_comb begin
        o_job.tag   = r_tag;
        o_job.found = r_found;
        o_job.ccol  = r_ccol;
        o_job.crow  = r_crow;
        o_job.sum   = n_sum;
        o_job.count = n_count;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed     <= 1'b0;
            r_found     <= 1'b0;
            r_in_frame  <= 1'b0;
            r_tag       <= '0;
            r_best_conf <= '0;
            r_best_box  <= '0;
            r_box       <= '0;
            r_ccol      <= '0;
            r_crow      <= '0;
            r_win       <= '0;
            r_sum       <= '0;
            r_count     <= '0;
        end else begin
            if (is_start) begin
                r_tag   <= i_tag;
                r_armed <= 1'b1;
            end
            if (is_box) begin
                if (i_last) begin
                    if (eff_conf != '0) begin
                        r_box  <= eff_box;
                        r_ccol <= centre_of(eff_box.left, eff_box.right);
                        r_crow <= centre_of(eff_box.top, eff_box.bottom);
                        r_found <= 1'b1;
                    end else begin
                        r_found <= 1'b0;
                    end
                    r_best_conf <= '0;
                    r_best_box  <= '0;
                end else begin
                    r_best_conf <= eff_conf;
                    r_best_box  <= eff_box;
                end
            end
            if (is_pix) begin
                r_win      <= win;
                r_sum      <= n_sum;
                r_count    <= n_count;
                r_in_frame <= !i_last;
                if (i_last) begin
                    r_armed <= 1'b0;
                end
            end
        end
    end

endmodule

// ----- rtl/drpl_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpl_queue
// Two-entry job queue between the front and the back.
// ----------------------------------------------------------------------------
module drpl_queue
    import drpl_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_job o_job
);

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_job   = r_mem[r_rp];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

endmodule

// ----- rtl/drpl_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpl_div
// Unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module drpl_div
    import drpl_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [DIV_NUM_BITS-1:0] i_num,
    input  logic [DIV_DEN_BITS-1:0] i_den,
    output logic                    o_done,
    output logic [DIV_NUM_BITS-1:0] o_quot
);

    localparam int CNT_BITS = $clog2(DIV_NUM_BITS + 1);
    localparam logic [CNT_BITS-1:0] STEPS = CNT_BITS'(DIV_NUM_BITS);

    logic [DIV_NUM_BITS-1:0] r_q;
    logic [DIV_DEN_BITS:0]   r_rem;
    logic [DIV_DEN_BITS-1:0] r_den;
    logic [CNT_BITS-1:0]     r_cnt;
    logic                    r_busy, r_done;

    logic [DIV_DEN_BITS+1:0] shifted, diff;

    assign shifted = {r_rem, r_q[DIV_NUM_BITS-1]};
    assign diff    = shifted - {2'b00, r_den};
    assign o_done  = r_done;
    assign o_quot  = r_q;

    // quotient bits shift in as numerator bits shift out
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_q    <= '0;
            r_rem  <= '0;
            r_den  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= STEPS;
                r_q    <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (diff[DIV_DEN_BITS+1]) begin
                    r_rem <= shifted[DIV_DEN_BITS:0];
                    r_q   <= {r_q[DIV_NUM_BITS-2:0], 1'b0};
                end else begin
                    r_rem <= diff[DIV_DEN_BITS:0];
                    r_q   <= {r_q[DIV_NUM_BITS-2:0], 1'b1};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule

// ----- rtl/drpl_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpl_back
// Per-frame result: mean depth division, pinhole projection of both axes on
// one shared divider, and the output register.
// ----------------------------------------------------------------------------
module drpl_back
    import drpl_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_empty,
    input  t_job                  i_job,
    output logic                  o_pop,
    input  logic [FOCAL_BITS-1:0] i_focal,
    input  logic [PRIN_BITS-1:0]  i_prin_x,
    input  logic [PRIN_BITS-1:0]  i_prin_y,
    output logic                  o_valid,
    input  logic                  i_ready,
    output t_result               o_res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MEAN  = 4'd1;
    localparam logic [3:0] S_MULX  = 4'd2;
    localparam logic [3:0] S_LDX   = 4'd3;
    localparam logic [3:0] S_DIVX  = 4'd4;
    localparam logic [3:0] S_MULY  = 4'd5;
    localparam logic [3:0] S_LDY   = 4'd6;
    localparam logic [3:0] S_DIVY  = 4'd7;
    localparam logic [3:0] S_DONE  = 4'd8;

    localparam int DIFF_BITS = COORD_BITS + 10;
    localparam int PROD_BITS = DIFF_BITS + RANGE_BITS + 1;
    localparam logic [OFF_BITS-1:0] OFF_MAX = {1'b0, {(OFF_BITS-1){1'b1}}};
    localparam logic [OFF_BITS-1:0] OFF_MIN = {1'b1, {(OFF_BITS-1){1'b0}}};

    logic [3:0]              r_state, n_state;
    t_job                    r_job;
    t_result                 r_res;
    logic                    r_valid;
    logic [RANGE_BITS-1:0]   r_mean;
    logic                    r_neg;
    logic [DIV_NUM_BITS-1:0] r_mag;

    logic                    div_start, div_done;
    logic [DIV_NUM_BITS-1:0] div_num, div_quot;
    logic [DIV_DEN_BITS-1:0] div_den;

    logic signed [DIFF_BITS-1:0] diff;
    logic signed [PROD_BITS-1:0] prod;
    logic [PROD_BITS-1:0]        prod_mag;
    logic [RANGE_BITS-1:0]       mean_sat;
    logic [OFF_BITS-1:0]         off;
    logic [FOCAL_BITS-1:0]       focal_nz;
    logic                        load_out;

    drpl_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign focal_nz = (i_focal == '0) ? FOCAL_BITS'(1) : i_focal;
    assign mean_sat = (div_quot > DIV_NUM_BITS'({RANGE_BITS{1'b1}})) ?
                      '1 : div_quot[RANGE_BITS-1:0];

    // centre in Q8 minus principal point, then times the mean depth
    always_comb begin
        if (r_state == S_MULY) begin
            diff = $signed({2'b00, r_job.crow, 8'h00}) -
                   $signed({{(DIFF_BITS-PRIN_BITS){1'b0}}, i_prin_y});
        end else begin
            diff = $signed({2'b00, r_job.ccol, 8'h00}) -
                   $signed({{(DIFF_BITS-PRIN_BITS){1'b0}}, i_prin_x});
        end
        prod     = PROD_BITS'(diff) * $signed({1'b0, r_mean});
        prod_mag = prod[PROD_BITS-1] ? PROD_BITS'(-prod) : PROD_BITS'(prod);
    end

    // signed, saturated offset from the magnitude quotient
    always_comb begin
        if (r_neg) begin
            off = (div_quot > DIV_NUM_BITS'(OFF_MIN)) ? OFF_MIN :
                  OFF_BITS'(-div_quot[OFF_BITS-1:0]);
        end else begin
            off = (div_quot > DIV_NUM_BITS'(OFF_MAX)) ? OFF_MAX : div_quot[OFF_BITS-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        div_start = 1'b0;
        div_num   = DIV_NUM_BITS'(r_job.sum);
        div_den   = DIV_DEN_BITS'(r_job.count);
        load_out  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_job.found && (i_job.count != '0)) begin
                        div_start = 1'b1;
                        div_num   = DIV_NUM_BITS'(i_job.sum);
                        div_den   = DIV_DEN_BITS'(i_job.count);
                        n_state   = S_MEAN;
                    end else begin
                        n_state = S_DONE;
                    end
                end
            end
            S_MEAN: if (div_done) n_state = S_MULX;
            S_MULX: n_state = S_LDX;
            S_LDX: begin
                div_start = 1'b1;
                div_num   = r_mag;
                div_den   = focal_nz;
                n_state   = S_DIVX;
            end
            S_DIVX: if (div_done) n_state = S_MULY;
            S_MULY: n_state = S_LDY;
            S_LDY: begin
                div_start = 1'b1;
                div_num   = r_mag;
                div_den   = focal_nz;
                n_state   = S_DIVY;
            end
            S_DIVY: if (div_done) n_state = S_DONE;
            S_DONE: begin
                if (!r_valid || i_ready) begin
                    load_out = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // the product is registered before it feeds the divider
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && o_pop) begin
            r_job <= i_job;
        end
        if (r_state == S_MEAN && div_done) begin
            r_mean <= mean_sat;
        end
        if (r_state == S_MULX || r_state == S_MULY) begin
            r_mag <= DIV_NUM_BITS'(prod_mag);
            r_neg <= prod[PROD_BITS-1];
        end
    end

    // result fields and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_res   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && o_pop) begin
                r_res.tag      <= i_job.tag;
                r_res.lateral  <= '0;
                r_res.vertical <= '0;
                r_res.range_mm <= '0;
                if (!i_job.found) begin
                    r_res.status <= ST_NO_OBJ;
                    r_res.ccol   <= '0;
                    r_res.crow   <= '0;
                end else begin
                    r_res.status <= (i_job.count == '0) ? ST_NO_DEPTH : ST_LOCATED;
                    r_res.ccol   <= i_job.ccol;
                    r_res.crow   <= i_job.crow;
                end
            end
            if (r_state == S_MEAN && div_done) begin
                r_res.range_mm <= mean_sat;
            end
            if (r_state == S_DIVX && div_done) begin
                r_res.lateral <= off;
            end
            if (r_state == S_DIVY && div_done) begin
                r_res.vertical <= off;
            end
            if (load_out) begin
                r_valid <= 1'b1;
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // held copy of the result that the port shows
    t_result r_out;
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_out;

endmodule

// ----- rtl/depth_roi_point_locator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_roi_point_locator
// Best-box selection, windowed depth mean and pinhole back-projection.
// ----------------------------------------------------------------------------
// Items are taken one per cycle whenever the two-entry job queue has room: box,
// start and depth pixel items never stall on their own. Only an armed frame end
// makes work for the back end, which runs the mean division and the two
// projection divisions one after the other on a single restoring divider (one
// quotient bit per cycle); only a located result waits on the divider, other
// results go straight to the output register. Input stalls only while the queue
// holds two frame ends behind the one the back end is working on.
module depth_roi_point_locator
    import drpl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [2:0]               i_cfg_idx,
    input  logic [FOCAL_BITS-1:0]    i_cfg_data,
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    // confidence, box_left, box_top, box_right, box_bottom, pixel_row,
    // pixel_col, depth_mm, request_tag
    input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,
    // func, box_present
    input  logic [2:0]               s_axis_tuser,
    input  logic                     s_axis_tlast,
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    // echo_tag, centre_col, centre_row, lateral_mm, vertical_mm, range_mm
    output logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    // status
    output logic [1:0]               m_axis_tuser
);

    logic [FOCAL_BITS-1:0] r_focal;
    logic [PRIN_BITS-1:0]  r_prin_x, r_prin_y;
    logic [HALF_BITS-1:0]  r_half_c, r_half_r;
    t_coord                r_last_c, r_last_r;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_focal  <= FOCAL_BITS'(158604);
            r_prin_x <= PRIN_BITS'(84125);
            r_prin_y <= PRIN_BITS'(60341);
            r_half_c <= HALF_BITS'(30);
            r_half_r <= HALF_BITS'(30);
            r_last_c <= COORD_BITS'(639);
            r_last_r <= COORD_BITS'(479);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FOCAL:  r_focal  <= i_cfg_data;
                CFG_PRIN_X: r_prin_x <= i_cfg_data[PRIN_BITS-1:0];
                CFG_PRIN_Y: r_prin_y <= i_cfg_data[PRIN_BITS-1:0];
                CFG_HALF_C: r_half_c <= i_cfg_data[HALF_BITS-1:0];
                CFG_HALF_R: r_half_r <= i_cfg_data[HALF_BITS-1:0];
                CFG_LAST_C: r_last_c <= i_cfg_data[COORD_BITS-1:0];
                CFG_LAST_R: r_last_r <= i_cfg_data[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    logic    q_full, q_empty, push, pop, take;
    t_job    push_job, pop_job;
    t_box    in_box;
    t_result res;

    assign s_axis_tready = !q_full;
    assign take          = s_axis_tvalid && s_axis_tready;

    assign in_box.left   = s_axis_tdata[IN_LEFT_LO +: COORD_BITS];
    assign in_box.top    = s_axis_tdata[IN_TOP_LO +: COORD_BITS];
    assign in_box.right  = s_axis_tdata[IN_RIGHT_LO +: COORD_BITS];
    assign in_box.bottom = s_axis_tdata[IN_BOTTOM_LO +: COORD_BITS];

    drpl_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (take),
        .i_func      (s_axis_tuser[1:0]),
        .i_last      (s_axis_tlast),
        .i_present   (s_axis_tuser[2]),
        .i_conf      (s_axis_tdata[IN_CONF_LO +: CONF_BITS]),
        .i_box       (in_box),
        .i_row       (s_axis_tdata[IN_ROW_LO +: COORD_BITS]),
        .i_col       (s_axis_tdata[IN_COL_LO +: COORD_BITS]),
        .i_depth     (s_axis_tdata[IN_DEPTH_LO +: DEPTH_BITS]),
        .i_tag       (s_axis_tdata[IN_TAG_LO +: TAG_BITS]),
        .i_half_cols (r_half_c),
        .i_half_rows (r_half_r),
        .i_last_col  (r_last_c),
        .i_last_row  (r_last_r),
        .o_push      (push),
        .o_job       (push_job)
    );

    drpl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (pop_job)
    );

    drpl_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (q_empty),
        .i_job    (pop_job),
        .o_pop    (pop),
        .i_focal  (r_focal),
        .i_prin_x (r_prin_x),
        .i_prin_y (r_prin_y),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_res    (res)
    );

    always_comb begin
        m_axis_tdata = '0;
        m_axis_tdata[OUT_TAG_LO +: TAG_BITS]     = res.tag;
        m_axis_tdata[OUT_CCOL_LO +: COORD_BITS]  = res.ccol;
        m_axis_tdata[OUT_CROW_LO +: COORD_BITS]  = res.crow;
        m_axis_tdata[OUT_LAT_LO +: OFF_BITS]     = res.lateral;
        m_axis_tdata[OUT_VERT_LO +: OFF_BITS]    = res.vertical;
        m_axis_tdata[OUT_RANGE_LO +: RANGE_BITS] = res.range_mm;
    end
    assign m_axis_tuser = res.status;

endmodule

// ----- rtl/drpl_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drpl_checker
// Port-level checks of the ROI point locator, bound to the top level.
// ----------------------------------------------------------------------------
module drpl_checker
    import drpl_pkg::*;
(
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     m_axis_tvalid,
    input logic                     m_axis_tready,
    input logic [OUT_DATA_BITS-1:0] m_axis_tdata,
    input logic [1:0]               m_axis_tuser
);

    // a result waits until taken
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // nothing is shown straight after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // no status beyond the defined codes
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser != 2'd3))
        else $error("undefined status");

    // nothing detected carries no centre column and no depth
    a_noobj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NO_OBJ) |->
        (m_axis_tdata[OUT_CCOL_LO +: COORD_BITS] == '0) &&
        (m_axis_tdata[OUT_RANGE_LO +: RANGE_BITS] == '0))
        else $error("no-object result carries data");

    // no valid depth gives zero range and zero lateral offset
    a_nodepth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_NO_DEPTH) |->
        (m_axis_tdata[OUT_RANGE_LO +: RANGE_BITS] == '0) &&
        (m_axis_tdata[OUT_LAT_LO +: OFF_BITS] == '0))
        else $error("no-depth result carries range");

endmodule

bind depth_roi_point_locator drpl_checker u_drpl_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for depth_roi_point_locator. Start, box-list and depth
// frame sequences with random content, mixed with noise items, are streamed
// in under random stalls on both sides. A behavioral predictor computes the
// result of each frame end, and every result is checked field by field.
// ----------------------------------------------------------------------------
module tb_top;
    import drpl_pkg::*;

    localparam int TIMEOUT_CYCLES = 300000;
    localparam int DRAIN_CYCLES   = 160;

    typedef struct {
        logic [1:0]  func;
        logic        last;
        logic        present;
        logic [15:0] conf;
        logic [10:0] left, top, right, bottom;
        logic [10:0] row, col;
        logic [15:0] depth;
        logic [15:0] tag;
    } t_item;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     i_cfg_we = 1'b0;
    logic [2:0]               i_cfg_idx = '0;
    logic [FOCAL_BITS-1:0]    i_cfg_data = '0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_DATA_BITS-1:0]  s_axis_tdata = '0;
    logic [2:0]               s_axis_tuser = '0;
    logic                     s_axis_tlast = 1'b0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b0;
    logic [OUT_DATA_BITS-1:0] m_axis_tdata;
    logic [1:0]               m_axis_tuser;

    depth_roi_point_locator uut (.*);

    always #1 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // shadow configuration and predictor state
    // ------------------------------------------------------------------
    longint focal = 158604, prin_x = 84125, prin_y = 60341;
    longint half_c = 30, half_r = 30, lim_c = 639, lim_r = 479;

    logic   armed = 0, found = 0, in_frame = 0;
    logic [15:0] held_tag = 0, best_conf = 0;
    longint best_l = 0, best_t = 0, best_r = 0, best_b = 0;
    longint com_l = 0, com_t = 0, com_r = 0, com_b = 0;
    longint cen_c = 0, cen_r = 0;
    longint win_x1 = 0, win_x2 = 0, win_y1 = 0, win_y2 = 0;
    longint depth_sum = 0, valid_count = 0;

    t_result expected_results[$];
    t_item   pending_items[$];
    t_item   cur_item;
    int      mismatches = 0;
    int      cycle = 0;
    logic    s_acc = 1'b0;

    function automatic longint back_project(longint c, longint p, longint mean);
        longint f, v;
        f = (focal == 0) ? 1 : focal;
        v = ((c * 256) - p) * mean / f;
        if (v < -131072) v = -131072;
        if (v > 131071) v = 131071;
        return v;
    endfunction

    // advance the predictor by one accepted item
    task automatic predict_item(input t_item it);
        t_result res;
        longint  v, mean;
        if (it.func == FUNC_START) begin
            held_tag = it.tag;
            armed = 1;
        end else if (it.func == FUNC_BOX) begin
            if (it.present && it.conf > best_conf) begin
                best_conf = it.conf;
                best_l = it.left; best_t = it.top; best_r = it.right; best_b = it.bottom;
            end
            if (it.last) begin
                if (best_conf > 0) begin
                    com_l = best_l; com_t = best_t; com_r = best_r; com_b = best_b;
                    cen_c = best_l + (best_r - best_l) / 2;
                    cen_r = best_t + (best_b - best_t) / 2;
                    found = 1;
                end else begin
                    found = 0;
                end
                best_conf = 0;
                best_l = 0; best_t = 0; best_r = 0; best_b = 0;
            end
        end else if (it.func == FUNC_PIXEL) begin
            // window latched at the first pixel of a frame
            if (!in_frame) begin
                v = cen_c - half_c; if (v < 0) v = 0; if (v < com_l) v = com_l; win_x1 = v;
                v = cen_c + half_c; if (v > lim_c) v = lim_c; if (v > com_r) v = com_r; win_x2 = v;
                v = cen_r - half_r; if (v < 0) v = 0; if (v < com_t) v = com_t; win_y1 = v;
                v = cen_r + half_r; if (v > lim_r) v = lim_r; if (v > com_b) v = com_b; win_y2 = v;
                depth_sum = 0;
                valid_count = 0;
                in_frame = 1;
            end
            if (it.depth != 0 && it.col > win_x1 && it.col < win_x2 &&
                it.row > win_y1 && it.row < win_y2) begin
                depth_sum = depth_sum + it.depth;
                if (depth_sum > 64'h0F_FFFF_FFFF) depth_sum = 64'h0F_FFFF_FFFF;
                if (valid_count < 262143) valid_count++;
            end
            if (it.last) begin
                in_frame = 0;
                if (armed) begin
                    armed = 0;
                    res = '0;
                    res.status = ST_NO_OBJ;
                    res.tag = held_tag;
                    if (found) begin
                        res.ccol = cen_c[10:0];
                        res.crow = cen_r[10:0];
                        if (valid_count == 0) begin
                            res.status = ST_NO_DEPTH;
                        end else begin
                            mean = depth_sum / valid_count;
                            if (mean > 65535) mean = 65535;
                            res.status = ST_LOCATED;
                            v = back_project(cen_c, prin_x, mean);
                            res.lateral = v[17:0];
                            v = back_project(cen_r, prin_y, mean);
                            res.vertical = v[17:0];
                            res.range_mm = mean[15:0];
                        end
                    end
                    expected_results.push_back(res);
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // driver: next item on the falling edge
    // ------------------------------------------------------------------
    function automatic logic take_idle();
        return ((cycle % 5000) >= 1500) && ($urandom_range(99) < 20);
    endfunction

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!s_axis_tvalid || s_acc) begin
                if (pending_items.size() != 0 && !take_idle()) begin
                    cur_item = pending_items.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tlast  <= cur_item.last;
                    s_axis_tuser  <= {cur_item.present, cur_item.func};
                    s_axis_tdata  <= IN_DATA_BITS'({cur_item.tag, cur_item.depth,
                                      cur_item.col, cur_item.row, cur_item.bottom,
                                      cur_item.right, cur_item.top, cur_item.left,
                                      cur_item.conf});
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
            m_axis_tready <= !take_idle();
        end
    end

    // ------------------------------------------------------------------
    // monitor: acceptance on the rising edge, prediction and result check
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_result exp_r, got;
        cycle <= cycle + 1;
        s_acc <= s_axis_tvalid && s_axis_tready;
        if (s_axis_tvalid && s_axis_tready)
            predict_item(cur_item);
        if (m_axis_tvalid && m_axis_tready) begin
            got.status   = m_axis_tuser;
            got.tag      = m_axis_tdata[OUT_TAG_LO +: TAG_BITS];
            got.ccol     = m_axis_tdata[OUT_CCOL_LO +: COORD_BITS];
            got.crow     = m_axis_tdata[OUT_CROW_LO +: COORD_BITS];
            got.lateral  = m_axis_tdata[OUT_LAT_LO +: OFF_BITS];
            got.vertical = m_axis_tdata[OUT_VERT_LO +: OFF_BITS];
            got.range_mm = m_axis_tdata[OUT_RANGE_LO +: RANGE_BITS];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result at cycle %0d: %p", cycle, got);
            end else begin
                exp_r = expected_results.pop_front();
                if (got != exp_r) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("result mismatch at cycle %0d\n  exp %p\n  got %p",
                                 cycle, exp_r, got);
                end
            end
        end
        if (cycle >= TIMEOUT_CYCLES) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // item builders
    // ------------------------------------------------------------------
    function automatic t_item noise_item();
        t_item it;
        it.func = 2'($urandom_range(3)); it.last = 1'($urandom_range(1));
        it.present = 1'($urandom_range(1)); it.conf = 16'($urandom());
        it.left = 11'($urandom()); it.top = 11'($urandom()); it.right = 11'($urandom());
        it.bottom = 11'($urandom()); it.row = 11'($urandom()); it.col = 11'($urandom());
        it.depth = 16'($urandom()); it.tag = 16'($urandom());
        return it;
    endfunction

    function automatic t_item start_item(input logic [15:0] tag);
        t_item it;
        it = noise_item();
        it.func = FUNC_START; it.tag = tag;
        return it;
    endfunction

    function automatic t_item box_item(input int cx, input int cy, input int spread,
                                       input logic [15:0] conf, input logic last);
        t_item it;
        int hw, hh;
        it = noise_item();
        hw = $urandom_range(spread); hh = $urandom_range(spread);
        it.func = FUNC_BOX; it.last = last; it.present = 1; it.conf = conf;
        it.left   = 11'((cx > hw) ? cx - hw : 0);
        it.right  = 11'((cx + hw > 2047) ? 2047 : cx + hw);
        it.top    = 11'((cy > hh) ? cy - hh : 0);
        it.bottom = 11'((cy + hh > 2047) ? 2047 : cy + hh);
        return it;
    endfunction

    function automatic t_item pixel_item(input int cx, input int cy, input int reach,
                                         input logic last);
        t_item it;
        int c, r;
        it = noise_item();
        it.func = FUNC_PIXEL; it.last = last;
        if ($urandom_range(9) < 8) begin
            c = cx + $urandom_range(2 * reach) - reach;
            r = cy + $urandom_range(2 * reach) - reach;
            it.col = 11'((c < 0) ? 0 : (c > 2047) ? 2047 : c);
            it.row = 11'((r < 0) ? 0 : (r > 2047) ? 2047 : r);
        end
        if ($urandom_range(9) == 0) it.depth = 0;
        return it;
    endfunction

    task automatic push_frame(input int cx, input int cy, input int reach, input int n);
        for (int k = 0; k < n; k++)
            pending_items.push_back(pixel_item(cx, cy, reach, k == n - 1));
    endtask

    // a start most of the time, a box list around one spot, then a depth frame over it
    task automatic push_sequence();
        int cx, cy, nb, reach;
        cx = $urandom_range(lim_c); cy = $urandom_range(lim_r);
        nb = $urandom_range(1, 4);
        reach = (half_c > 40) ? 40 : half_c + 2;
        if ($urandom_range(3) != 0) pending_items.push_back(start_item(16'($urandom())));
        for (int k = 0; k < nb; k++)
            pending_items.push_back(box_item(cx, cy, 60,
                ($urandom_range(7) == 0) ? 16'd0 : 16'($urandom()), k == nb - 1));
        push_frame(cx, cy, reach, $urandom_range(3, 24));
    endtask

    task automatic write_reg(input logic [2:0] idx, input longint val);
        @(negedge i_clk);
        i_cfg_we = 1'b1; i_cfg_idx = idx; i_cfg_data = val[FOCAL_BITS-1:0];
        case (idx)
            CFG_FOCAL:  focal  = val;
            CFG_PRIN_X: prin_x = val;
            CFG_PRIN_Y: prin_y = val;
            CFG_HALF_C: half_c = val;
            CFG_HALF_R: half_r = val;
            CFG_LAST_C: lim_c  = val;
            CFG_LAST_R: lim_r  = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic write_all(input longint f, input longint px, input longint py,
                             input longint hc, input longint hr,
                             input longint lc, input longint lr);
        write_reg(CFG_FOCAL, f);   write_reg(CFG_PRIN_X, px); write_reg(CFG_PRIN_Y, py);
        write_reg(CFG_HALF_C, hc); write_reg(CFG_HALF_R, hr);
        write_reg(CFG_LAST_C, lc); write_reg(CFG_LAST_R, lr);
    endtask

    task automatic wait_idle();
        wait (pending_items.size() == 0 && !s_axis_tvalid && expected_results.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial begin
        t_item it;
        int    fed;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: frame end while unarmed, unused kind
        push_frame(320, 240, 20, 2);
        it = noise_item(); it.func = 2'd3; pending_items.push_back(it);
        // empty list marker gives nothing detected
        pending_items.push_back(start_item(16'hFFFF));
        it = box_item(100, 100, 10, 16'hFFFF, 1); it.present = 0;
        pending_items.push_back(it);
        push_frame(100, 100, 5, 2);
        // all-zero confidences, start while armed
        pending_items.push_back(start_item(16'h0000));
        pending_items.push_back(start_item(16'h1234));
        pending_items.push_back(box_item(50, 50, 10, 16'd0, 0));
        pending_items.push_back(box_item(60, 60, 10, 16'd0, 1));
        push_frame(50, 50, 5, 2);
        // right below left; tie keeps the first box; zero depth frame
        pending_items.push_back(start_item(16'hA5A5));
        it = box_item(300, 200, 0, 16'd7, 0);
        it.left = 2047; it.right = 0; it.top = 2047; it.bottom = 0;
        pending_items.push_back(it);
        pending_items.push_back(box_item(320, 240, 30, 16'd7, 1));
        it = pixel_item(0, 0, 0, 1); it.depth = 0; pending_items.push_back(it);
        // located with max depth
        pending_items.push_back(start_item(16'h5A5A));
        pending_items.push_back(box_item(320, 240, 50, 16'hFFFF, 1));
        for (int k = 0; k < 4; k++) begin
            it = pixel_item(320, 240, 10, k == 3); it.depth = 16'hFFFF;
            pending_items.push_back(it);
        end
        wait_idle();

        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                1: write_all(1, 0, 0, 255, 255, 2047, 2047);
                2: write_all(1048575, 524287, 524287, 0, 0, 0, 0);
                3: write_all($urandom_range(1, 1048575), $urandom_range(524287),
                             $urandom_range(524287), $urandom_range(1, 60),
                             $urandom_range(1, 60), $urandom_range(100, 2047),
                             $urandom_range(100, 2047));
                4: write_all($urandom_range(1, 4000), $urandom_range(524287),
                             $urandom_range(524287), 5, 3, 1023, 767);
                default: ;
            endcase
            fed = 0;
            while (fed < 185) begin
                int queued;
                queued = pending_items.size();
                if ($urandom_range(3) != 0) push_sequence();
                else pending_items.push_back(noise_item());
                fed += pending_items.size() - queued;
                wait (pending_items.size() < 40);
            end
            wait_idle();
        end

        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
